@@ rtl/ate_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ate_pkg
// Operation and status codes and field widths for the array table engine.
// ----------------------------------------------------------------------------
package ate_pkg;

	localparam int OP_W    = 3;
	localparam int WORD_W  = 32;
	localparam int IDX_W   = 7;
	localparam int STAT_W  = 2;
	localparam int FOUND_W = 6;
	localparam int FILL_W  = 7;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 3'd0,
		OP_APPEND = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_SORT   = 3'd4,
		OP_SEARCH = 3'd5,
		OP_READ   = 3'd6,
		OP_NONE   = 3'd7
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_RANGE   = 2'd2,
		ST_MISSING = 2'd3
	} status_t;

endpackage : ate_pkg
`default_nettype wire

@@ rtl/array_table_engine_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// array_table_engine_top
// Packed table of signed 32-bit words with clear, append, insert, delete,
// exchange sort, search and read.
// ----------------------------------------------------------------------------
// One word in gives one word out, carrying a status and the fill count after
// the operation. All table traffic goes through a single-port-write,
// registered-read memory, and one comparator serves both search and sort, so
// an operation proceeds one memory move or compare at a time, each a read
// state followed by a write or compare state. A new word is taken only while
// the sequencer is idle; a finished result waits in the output register
// without holding off the next input word.
// ----------------------------------------------------------------------------
module array_table_engine_top
	import ate_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,   // data_value[31:0], slot_index[38:32]
	input  wire logic [2:0]  s_axis_tuser,   // operation[2:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [47:0]      m_axis_tdata,   // read_value[31:0], found_index[37:32],
	                                         // fill_count[44:38]
	output logic [1:0]       m_axis_tuser    // status[1:0]
);

	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int IW   = $clog2(DEPTH + 1);
	localparam int CMPW = (IW > IDX_W) ? IW : IDX_W;

	typedef enum logic [15:0] {
		S_IDLE     = 16'b0000_0000_0000_0001,
		S_DONE     = 16'b0000_0000_0000_0010,
		S_INS_RD   = 16'b0000_0000_0000_0100,
		S_INS_WR   = 16'b0000_0000_0000_1000,
		S_INS_PUT  = 16'b0000_0000_0001_0000,
		S_DEL_RD   = 16'b0000_0000_0010_0000,
		S_DEL_WR   = 16'b0000_0000_0100_0000,
		S_SRCH_RD  = 16'b0000_0000_1000_0000,
		S_SRCH_CMP = 16'b0000_0001_0000_0000,
		S_READ_RD  = 16'b0000_0010_0000_0000,
		S_READ_GET = 16'b0000_0100_0000_0000,
		S_SORT_RDP = 16'b0000_1000_0000_0000,
		S_SORT_LDP = 16'b0001_0000_0000_0000,
		S_SORT_RDQ = 16'b0010_0000_0000_0000,
		S_SORT_CMP = 16'b0100_0000_0000_0000,
		S_SORT_WRP = 16'b1000_0000_0000_0000
	} state_t;

	state_t              st_q;
	logic [IW-1:0]       count_q;
	logic [IW-1:0]       k_q;      // walk index (insert, delete, search, read, sort inner)
	logic [IW-1:0]       p_q;      // sort outer index
	logic [IW-1:0]       idx_q;
	logic [WORD_W-1:0]   a_q;      // comparator operand: key, insert value or sort pivot
	status_t             res_status_q;
	logic [WORD_W-1:0]   res_rd_q;
	logic [FOUND_W-1:0]  res_found_q;
	logic                out_valid_q;
	status_t             out_status_q;
	logic [WORD_W-1:0]   out_rd_q;
	logic [FOUND_W-1:0]  out_found_q;
	logic [FILL_W-1:0]   out_fill_q;

	logic [WORD_W-1:0]   mem [DEPTH];
	logic [WORD_W-1:0]   rdata_q;
	logic                we;
	logic [AW-1:0]       waddr;
	logic [WORD_W-1:0]   wdata;
	logic [AW-1:0]       raddr;

	op_t                 in_op;
	logic [WORD_W-1:0]   in_val;
	logic [IDX_W-1:0]    in_idx;
	logic [IW-1:0]       in_idx_k;
	logic [CMPW-1:0]     idx_ext;
	logic [CMPW-1:0]     cnt_ext;
	logic                acc;
	logic                full;
	logic                cmp_gt;
	logic                cmp_eq;
	logic                out_load;

	assign in_op    = op_t'(s_axis_tuser);
	assign in_val   = s_axis_tdata[31:0];
	assign in_idx   = s_axis_tdata[38:32];
	assign in_idx_k = IW'(in_idx);
	assign idx_ext  = CMPW'(in_idx);
	assign cnt_ext  = CMPW'(count_q);
	assign full     = (count_q == IW'(DEPTH));

	assign s_axis_tready = (st_q == S_IDLE);
	assign acc           = s_axis_tvalid && s_axis_tready;

	// shared compare unit
	assign cmp_gt = ($signed(a_q) > $signed(rdata_q));
	assign cmp_eq = (a_q == rdata_q);

	assign out_load = (st_q == S_DONE) && (!out_valid_q || m_axis_tready);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = count_q[AW-1:0];
		wdata = rdata_q;
		raddr = k_q[AW-1:0];
		case (st_q)
			S_IDLE: begin
				wdata = in_val;
				if (acc && !full && ((in_op == OP_APPEND) ||
				    ((in_op == OP_INSERT) && (idx_ext == cnt_ext))))
					we = 1'b1;
			end
			S_INS_RD: begin
				raddr = AW'(k_q - 1'b1);
			end
			S_INS_WR: begin
				we    = 1'b1;
				waddr = k_q[AW-1:0];
			end
			S_INS_PUT: begin
				we    = 1'b1;
				waddr = idx_q[AW-1:0];
				wdata = a_q;
			end
			S_DEL_RD: begin
				raddr = AW'(k_q + 1'b1);
			end
			S_DEL_WR: begin
				we    = 1'b1;
				waddr = k_q[AW-1:0];
			end
			S_SORT_RDP: begin
				raddr = p_q[AW-1:0];
			end
			S_SORT_CMP: begin
				we    = cmp_gt;
				waddr = k_q[AW-1:0];
				wdata = a_q;
			end
			S_SORT_WRP: begin
				we    = 1'b1;
				waddr = p_q[AW-1:0];
				wdata = a_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= S_IDLE;
			count_q      <= '0;
			k_q          <= '0;
			p_q          <= '0;
			idx_q        <= '0;
			a_q          <= '0;
			res_status_q <= ST_OK;
			res_rd_q     <= '0;
			res_found_q  <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_rd_q     <= '0;
			out_found_q  <= '0;
			out_fill_q   <= '0;
		end else begin
			if (out_load) begin
				out_valid_q  <= 1'b1;
				out_status_q <= res_status_q;
				out_rd_q     <= res_rd_q;
				out_found_q  <= res_found_q;
				out_fill_q   <= FILL_W'(count_q);
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (st_q)
				S_IDLE: begin
					if (acc) begin
						res_status_q <= ST_OK;
						res_rd_q     <= '0;
						res_found_q  <= '0;
						a_q          <= in_val;
						idx_q        <= in_idx_k;
						st_q         <= S_DONE;
						case (in_op)
							OP_CLEAR: begin
								count_q <= '0;
							end
							OP_APPEND: begin
								if (full)
									res_status_q <= ST_FULL;
								else
									count_q <= count_q + 1'b1;
							end
							OP_INSERT: begin
								if (full) begin
									res_status_q <= ST_FULL;
								end else if (idx_ext > cnt_ext) begin
									res_status_q <= ST_RANGE;
								end else if (idx_ext == cnt_ext) begin
									count_q <= count_q + 1'b1;
								end else begin
									k_q  <= count_q;
									st_q <= S_INS_RD;
								end
							end
							OP_DELETE: begin
								if (idx_ext >= cnt_ext) begin
									res_status_q <= ST_RANGE;
								end else begin
									k_q <= in_idx_k;
									if (IW'(in_idx_k + 1'b1) >= count_q)
										count_q <= count_q - 1'b1;
									else
										st_q <= S_DEL_RD;
								end
							end
							OP_SORT: begin
								p_q <= '0;
								if (count_q > IW'(1))
									st_q <= S_SORT_RDP;
							end
							OP_SEARCH: begin
								res_status_q <= ST_MISSING;
								k_q          <= '0;
								if (count_q != '0)
									st_q <= S_SRCH_RD;
							end
							OP_READ: begin
								if (idx_ext >= cnt_ext) begin
									res_status_q <= ST_RANGE;
								end else begin
									k_q  <= in_idx_k;
									st_q <= S_READ_RD;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_DONE: begin
					if (out_load)
						st_q <= S_IDLE;
				end
				S_INS_RD: begin
					st_q <= S_INS_WR;
				end
				S_INS_WR: begin
					k_q <= k_q - 1'b1;
					if (IW'(k_q - 1'b1) == idx_q)
						st_q <= S_INS_PUT;
					else
						st_q <= S_INS_RD;
				end
				S_INS_PUT: begin
					count_q <= count_q + 1'b1;
					st_q    <= S_DONE;
				end
				S_DEL_RD: begin
					st_q <= S_DEL_WR;
				end
				S_DEL_WR: begin
					k_q <= k_q + 1'b1;
					if (IW'(k_q + 2'd2) < count_q) begin
						st_q <= S_DEL_RD;
					end else begin
						count_q <= count_q - 1'b1;
						st_q    <= S_DONE;
					end
				end
				S_SRCH_RD: begin
					st_q <= S_SRCH_CMP;
				end
				S_SRCH_CMP: begin
					if (cmp_eq) begin
						res_status_q <= ST_OK;
						res_found_q  <= FOUND_W'(k_q);
						st_q         <= S_DONE;
					end else begin
						k_q <= k_q + 1'b1;
						if (IW'(k_q + 1'b1) < count_q)
							st_q <= S_SRCH_RD;
						else
							st_q <= S_DONE;
					end
				end
				S_READ_RD: begin
					st_q <= S_READ_GET;
				end
				S_READ_GET: begin
					res_rd_q <= rdata_q;
					st_q     <= S_DONE;
				end
				S_SORT_RDP: begin
					st_q <= S_SORT_LDP;
				end
				S_SORT_LDP: begin
					a_q  <= rdata_q;
					k_q  <= IW'(p_q + 1'b1);
					st_q <= S_SORT_RDQ;
				end
				S_SORT_RDQ: begin
					st_q <= S_SORT_CMP;
				end
				S_SORT_CMP: begin
					// pivot word for slot p lives in a_q until the inner pass ends
					if (cmp_gt)
						a_q <= rdata_q;
					k_q <= k_q + 1'b1;
					if (IW'(k_q + 1'b1) < count_q)
						st_q <= S_SORT_RDQ;
					else
						st_q <= S_SORT_WRP;
				end
				S_SORT_WRP: begin
					p_q <= p_q + 1'b1;
					if (IW'(p_q + 2'd2) < count_q)
						st_q <= S_SORT_RDP;
					else
						st_q <= S_DONE;
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_fill_q, out_found_q, out_rd_q};
	assign m_axis_tuser  = out_status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= IW'(DEPTH))
		else $error("fill count above depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == $past(count_q) || count_q == $past(count_q) + 1'b1 ||
		          count_q == $past(count_q) - 1'b1 || count_q == '0))
		else $error("fill count moved by more than one");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && in_op == OP_CLEAR) |=> (count_q == '0))
		else $error("clear left entries");

	a_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (IW'(waddr) <= count_q))
		else $error("write beyond fill count");

	a_result_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (st_q == S_IDLE))
		else $error("result loaded without return to idle");

endmodule : array_table_engine_top
`default_nettype wire

@@ tb/array_table_engine_top_tb.sv @@
// ----------------------------------------------------------------------------
// array_table_engine_top_tb
// Drives table operations into the engine over the input stream and scores
// every output word against a shadow copy of the table. A directed walk
// covers empty, full and boundary cases. Random phases of filling, draining
// and mixed traffic follow, with random idling on both streams.
// ----------------------------------------------------------------------------
module array_table_engine_top_tb
	import ate_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH        = 64;
	localparam int RANDOM_WORDS = 800;
	localparam int QUIET_LIMIT  = 20000;   // must outlast a full-table sort
	localparam logic [31:0] WORD_MIN = 32'h8000_0000;
	localparam logic [31:0] WORD_MAX = 32'h7FFF_FFFF;

	typedef struct packed {
		status_t     st;
		logic [31:0] rd;
		logic [5:0]  fi;
		logic [6:0]  fc;
	} table_reply_t;

	typedef struct {
		op_t          op;
		logic [31:0]  v;
		logic [6:0]   ix;
		int           reps;    // repeated rows take a random value each time
		bit           typed;
		table_reply_t want;
	} drill_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;    // data_value[31:0], slot_index[38:32]
	logic [2:0]  s_axis_tuser = '0;    // operation[2:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;         // read_value[31:0], found_index[37:32],
	                                   // fill_count[44:38]
	logic [1:0]  m_axis_tuser;         // status[1:0]

	logic signed [31:0] shadow_words [DEPTH];
	int                 shadow_fill = 0;
	table_reply_t       pending_replies [$];
	drill_row_t         drill_rows [$];
	int                 bad_words = 0;
	int                 shown = 0;
	int                 quiet = 0;
	bit                 steady = 1'b0;

	array_table_engine_top #(.DEPTH(DEPTH)) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Applies one operation to the shadow table, returns the reply word.
	function automatic table_reply_t apply_table_op(op_t op, logic signed [31:0] v,
			logic [6:0] ix);
		table_reply_t       r;
		int                 k, p, q;
		bit                 hit;
		logic signed [31:0] t;
		r.st = ST_OK;
		r.rd = '0;
		r.fi = '0;
		r.fc = '0;
		hit = 1'b0;
		case (op)
			OP_CLEAR: shadow_fill = 0;
			OP_APPEND: begin
				if (shadow_fill >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					shadow_words[shadow_fill] = v;
					shadow_fill++;
				end
			end
			OP_INSERT: begin
				// full is checked ahead of the index
				if (shadow_fill >= DEPTH) begin
					r.st = ST_FULL;
				end else if (int'(ix) > shadow_fill) begin
					r.st = ST_RANGE;
				end else begin
					for (k = shadow_fill; k > int'(ix); k--)
						shadow_words[k] = shadow_words[k - 1];
					shadow_words[ix] = v;
					shadow_fill++;
				end
			end
			OP_DELETE: begin
				if (int'(ix) >= shadow_fill) begin
					r.st = ST_RANGE;
				end else begin
					for (k = int'(ix); k + 1 < shadow_fill; k++)
						shadow_words[k] = shadow_words[k + 1];
					shadow_fill--;
				end
			end
			OP_SORT: begin
				for (p = 0; p < shadow_fill; p++)
					for (q = p + 1; q < shadow_fill; q++)
						if (shadow_words[p] > shadow_words[q]) begin
							t = shadow_words[p];
							shadow_words[p] = shadow_words[q];
							shadow_words[q] = t;
						end
			end
			OP_SEARCH: begin
				r.st = ST_MISSING;
				for (k = 0; k < shadow_fill; k++)
					if (!hit && shadow_words[k] == v) begin
						hit = 1'b1;
						r.fi = 6'(k);
						r.st = ST_OK;
					end
			end
			OP_READ: begin
				if (int'(ix) >= shadow_fill)
					r.st = ST_RANGE;
				else
					r.rd = shadow_words[ix];
			end
			default: ;
		endcase
		r.fc = 7'(shadow_fill);
		return r;
	endfunction

	function automatic void add_row(op_t op, logic [31:0] v, logic [6:0] ix, bit typed,
			status_t st, logic [31:0] rd, logic [5:0] fi, logic [6:0] fc, int reps = 1);
		drill_row_t row;
		row.op = op;
		row.v = v;
		row.ix = ix;
		row.reps = reps;
		row.typed = typed;
		row.want.st = st;
		row.want.rd = rd;
		row.want.fi = fi;
		row.want.fc = fc;
		drill_rows.push_back(row);
	endfunction

	function automatic logic [31:0] pick_word();
		int          k;
		logic [31:0] w;
		k = $urandom_range(99);
		if (k < 50)
			return $urandom;
		if (k < 75) begin
			// narrow range, so duplicates show up
			w = $urandom_range(8);
			return w - 32'd4;
		end
		if (k < 85) begin
			case ($urandom_range(3))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return 32'h0;
				default: return 32'hFFFF_FFFF;
			endcase
		end
		if (shadow_fill > 0)
			return shadow_words[$urandom_range(shadow_fill - 1)];
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_key();
		if (shadow_fill > 0 && $urandom_range(99) < 60)
			return shadow_words[$urandom_range(shadow_fill - 1)];
		return pick_word();
	endfunction

	function automatic logic [6:0] pick_slot(op_t op);
		int k, lim;
		k = $urandom_range(99);
		lim = (op == OP_INSERT) ? shadow_fill : shadow_fill - 1;
		if (k < 70 && lim >= 0)
			return 7'($urandom_range(lim));
		if (k < 85) begin
			if (op == OP_INSERT)
				return 7'((shadow_fill < DEPTH) ? shadow_fill + 1 : DEPTH);
			return 7'(shadow_fill);
		end
		return 7'($urandom_range(DEPTH));
	endfunction

	// mode 0 fills the table, 1 drains it, 2 mixes everything
	function automatic op_t pick_op(int mode);
		int k;
		k = $urandom_range(99);
		case (mode)
			0: begin
				if (k < 45) return OP_APPEND;
				if (k < 75) return OP_INSERT;
				if (k < 80) return OP_DELETE;
				if (k < 87) return OP_SEARCH;
				if (k < 96) return OP_READ;
				if (k < 99) return OP_SORT;
				return OP_NONE;
			end
			1: begin
				if (k < 45) return OP_DELETE;
				if (k < 55) return OP_INSERT;
				if (k < 60) return OP_APPEND;
				if (k < 72) return OP_SEARCH;
				if (k < 92) return OP_READ;
				if (k < 96) return OP_SORT;
				if (k < 98) return OP_CLEAR;
				return OP_NONE;
			end
			default: begin
				if (k < 20) return OP_APPEND;
				if (k < 40) return OP_INSERT;
				if (k < 60) return OP_DELETE;
				if (k < 75) return OP_SEARCH;
				if (k < 90) return OP_READ;
				if (k < 95) return OP_SORT;
				if (k < 98) return OP_CLEAR;
				return OP_NONE;
			end
		endcase
	endfunction

	// Offers one word, waits for it to be taken, then logs its expected reply.
	task automatic send_word(op_t op, logic [31:0] v, logic [6:0] ix, bit typed,
			table_reply_t want);
		table_reply_t r;
		if (!steady && $urandom_range(99) < 7) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, ix, v};
		s_axis_tuser <= op;
		do @(posedge clk); while (!s_axis_tready);
		r = apply_table_op(op, v, ix);
		pending_replies.push_back(typed ? want : r);
	endtask

	always @(posedge clk) begin
		table_reply_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.st = status_t'(m_axis_tuser);
			got.rd = m_axis_tdata[31:0];
			got.fi = m_axis_tdata[37:32];
			got.fc = m_axis_tdata[44:38];
			if (pending_replies.size() == 0) begin
				bad_words++;
				if (shown < 10)
					$display("%0t: unexpected word st=%0d rd=%h fi=%0d fc=%0d",
						$realtime, got.st, got.rd, got.fi, got.fc);
				shown++;
			end else begin
				want = pending_replies.pop_front();
				if (got !== want || m_axis_tdata[47:45] !== 3'b000) begin
					bad_words++;
					if (shown < 10)
						$display("%0t: want %0d/%h/%0d/%0d got %0d/%h/%0d/%0d pad %b",
							$realtime, want.st, want.rd, want.fi, want.fc,
							got.st, got.rd, got.fi, got.fc, m_axis_tdata[47:45]);
					shown++;
				end
			end
		end
		m_axis_tready <= steady || ($urandom_range(99) >= 7);
	end

	// watchdog: cycles with no word taken on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		drill_row_t  row;
		int          n, r, k, mode, phase_left;
		op_t         op;
		logic [31:0] v;
		logic [6:0]  ix;

		// empty table
		add_row(OP_READ,   32'h0,      7'd0,  1, ST_RANGE,   32'h0,    6'd0, 7'd0);
		add_row(OP_SEARCH, 32'h0,      7'd0,  1, ST_MISSING, 32'h0,    6'd0, 7'd0);
		add_row(OP_SORT,   32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd0);
		add_row(OP_DELETE, 32'h0,      7'd0,  1, ST_RANGE,   32'h0,    6'd0, 7'd0);
		add_row(OP_INSERT, 32'd5,      7'd1,  1, ST_RANGE,   32'h0,    6'd0, 7'd0);
		// small table with extreme values: {-1, MAX, MIN, 0}
		add_row(OP_APPEND, WORD_MAX,   7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd1);
		add_row(OP_APPEND, WORD_MIN,   7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd2);
		add_row(OP_INSERT, 32'hFFFF_FFFF, 7'd0, 1, ST_OK,    32'h0,    6'd0, 7'd3);
		add_row(OP_INSERT, 32'h0,      7'd3,  1, ST_OK,      32'h0,    6'd0, 7'd4);
		add_row(OP_READ,   32'h0,      7'd1,  1, ST_OK,      WORD_MAX, 6'd0, 7'd4);
		add_row(OP_READ,   32'h0,      7'd4,  1, ST_RANGE,   32'h0,    6'd0, 7'd4);
		add_row(OP_SEARCH, WORD_MIN,   7'd0,  1, ST_OK,      32'h0,    6'd2, 7'd4);
		add_row(OP_SORT,   32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd4);
		add_row(OP_READ,   32'h0,      7'd0,  1, ST_OK,      WORD_MIN, 6'd0, 7'd4);
		add_row(OP_NONE,   32'hFFFF_FFFF, 7'd0, 1, ST_OK,    32'h0,    6'd0, 7'd4);
		add_row(OP_DELETE, 32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd3);
		add_row(OP_DELETE, 32'h0,      7'd2,  1, ST_OK,      32'h0,    6'd0, 7'd2);
		add_row(OP_SEARCH, 32'd5,      7'd0,  1, ST_MISSING, 32'h0,    6'd0, 7'd2);
		add_row(OP_READ,   32'h0,      7'd64, 1, ST_RANGE,   32'h0,    6'd0, 7'd2);
		add_row(OP_CLEAR,  32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd0);
		// full table
		add_row(OP_APPEND, 32'h0,      7'd0,  0, ST_OK,      32'h0,    6'd0, 7'd0, DEPTH);
		add_row(OP_APPEND, 32'd1,      7'd0,  1, ST_FULL,    32'h0,    6'd0, 7'd64);
		add_row(OP_INSERT, 32'd1,      7'd0,  1, ST_FULL,    32'h0,    6'd0, 7'd64);
		add_row(OP_DELETE, 32'h0,      7'd63, 1, ST_OK,      32'h0,    6'd0, 7'd63);
		add_row(OP_INSERT, 32'd1,      7'd64, 1, ST_RANGE,   32'h0,    6'd0, 7'd63);
		add_row(OP_INSERT, WORD_MIN,   7'd63, 1, ST_OK,      32'h0,    6'd0, 7'd64);
		add_row(OP_READ,   32'h0,      7'd63, 1, ST_OK,      WORD_MIN, 6'd0, 7'd64);
		add_row(OP_SORT,   32'h0,      7'd0,  0, ST_OK,      32'h0,    6'd0, 7'd0);
		add_row(OP_READ,   32'h0,      7'd0,  1, ST_OK,      WORD_MIN, 6'd0, 7'd64);
		add_row(OP_SEARCH, WORD_MIN,   7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd64);
		add_row(OP_DELETE, 32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd63);
		add_row(OP_CLEAR,  32'h0,      7'd0,  1, ST_OK,      32'h0,    6'd0, 7'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < drill_rows.size(); n++) begin
			row = drill_rows[n];
			for (r = 0; r < row.reps; r++) begin
				v = (row.reps > 1) ? $urandom : row.v;
				send_word(row.op, v, row.ix, row.typed, row.want);
			end
		end

		phase_left = 0;
		mode = 0;
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (phase_left == 0) begin
				k = $urandom_range(99);
				mode = (k < 50) ? 0 : (k < 70) ? 1 : 2;
				phase_left = $urandom_range(40, 90);
			end
			phase_left--;
			steady <= (n >= 300 && n < 450);
			op = pick_op(mode);
			ix = pick_slot(op);
			v = (op == OP_SEARCH) ? pick_key() : pick_word();
			send_word(op, v, ix, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;

		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);

		bad_words += pending_replies.size();
		if (bad_words == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule : array_table_engine_top_tb
